/* rtl/core/lcdn_pkg.sv */
// shared types and constants of the 4-bit character display controller
package lcdn_pkg;

	localparam logic [1:0] OP_CMD    = 2'd0;
	localparam logic [1:0] OP_DATA   = 2'd1;
	localparam logic [1:0] OP_CURSOR = 2'd2;
	localparam logic [1:0] OP_INIT   = 2'd3;

	localparam logic [1:0] CFG_PULSE     = 2'd0;
	localparam logic [1:0] CFG_SETTLE    = 2'd1;
	localparam logic [1:0] CFG_INIT_WAIT = 2'd2;

	localparam logic [7:0] PULSE_RST     = 8'd1;
	localparam logic [7:0] SETTLE_RST    = 8'd2;
	localparam logic [7:0] INIT_WAIT_RST = 8'd5;

	// segments of a request; a plain byte request runs only the last byte segment
	localparam logic [3:0] SEG_ZERO      = 4'd0;
	localparam logic [3:0] SEG_WAKE_1    = 4'd1;
	localparam logic [3:0] SEG_WAKE_3    = 4'd3;
	localparam logic [3:0] SEG_NIB2      = 4'd4;
	localparam logic [3:0] SEG_BYTE_1    = 4'd5;
	localparam logic [3:0] SEG_BYTE_LAST = 4'd8;

	localparam logic [2:0] SUB_ZERO_END = 3'd0;
	localparam logic [2:0] SUB_WAKE_END = 3'd2;
	localparam logic [2:0] SUB_NIB2_END = 3'd1;
	localparam logic [2:0] SUB_BYTE_END = 3'd4;

	localparam logic [3:0] NIB_WAKE  = 4'h3;
	localparam logic [3:0] NIB_4BIT  = 4'h2;
	localparam logic [5:0] COL_MAX   = 6'd40;

	localparam logic [7:0] CMD_FUNC_SET = 8'h28;
	localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
	localparam logic [7:0] CMD_ENTRY    = 8'h06;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;

	typedef struct packed {
		logic [7:0] pulse_ms;
		logic [7:0] settle_ms;
		logic [7:0] init_wait_ms;
	} cfg_t;

	typedef struct packed {
		logic       reg_select;
		logic       enable;
		logic [3:0] nibble;
		logic [7:0] hold_ms;
		logic       last;
	} phase_t;

	// command byte sent in each byte segment of the power-up sequence
	function automatic logic [7:0] init_cmd(input logic [3:0] seg);
		logic [7:0] cmd;
		unique case (seg)
			4'd5:    cmd = CMD_FUNC_SET;
			4'd6:    cmd = CMD_DISP_ON;
			4'd7:    cmd = CMD_ENTRY;
			default: cmd = CMD_CLEAR;
		endcase
		return cmd;
	endfunction

endpackage

/* rtl/core/lcdn_if.sv */
// request, phase and configuration channels of the display controller
interface lcdn_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] byte_value;
	logic [1:0] row;
	logic [5:0] column;
	modport source (output valid, opcode, byte_value, row, column, input ready);
	modport sink (input valid, opcode, byte_value, row, column, output ready);
endinterface

interface lcdn_rsp_if;
	logic       valid;
	logic       ready;
	logic       reg_select;
	logic       enable;
	logic [3:0] nibble;
	logic [7:0] hold_ms;
	logic       last;
	modport source (output valid, reg_select, enable, nibble, hold_ms, last, input ready);
	modport sink (input valid, reg_select, enable, nibble, hold_ms, last, output ready);
endinterface

interface lcdn_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/lcdn_phase.sv */
// phase generator: pin levels and hold time of one step of a segment
module lcdn_phase (
	input  logic [3:0]      seg,
	input  logic [2:0]      sub,
	input  logic [7:0]      byte_value,
	input  logic            reg_select,
	input  lcdn_pkg::cfg_t  cfg,
	output lcdn_pkg::phase_t phase,
	output logic            seg_done
);

	logic is_wake;

	assign is_wake = (seg >= lcdn_pkg::SEG_WAKE_1) && (seg <= lcdn_pkg::SEG_WAKE_3);

	always_comb begin
		phase = '0;
		seg_done = 1'b0;
		priority if (seg == lcdn_pkg::SEG_ZERO) begin
			seg_done = (sub == lcdn_pkg::SUB_ZERO_END);
		end else if (is_wake) begin
			phase.enable = (sub == 3'd0);
			phase.nibble = lcdn_pkg::NIB_WAKE;
			phase.hold_ms = (sub == lcdn_pkg::SUB_WAKE_END) ? cfg.init_wait_ms : cfg.pulse_ms;
			seg_done = (sub == lcdn_pkg::SUB_WAKE_END);
		end else if (seg == lcdn_pkg::SEG_NIB2) begin
			phase.enable = (sub == 3'd0);
			phase.nibble = lcdn_pkg::NIB_4BIT;
			phase.hold_ms = cfg.pulse_ms;
			seg_done = (sub == lcdn_pkg::SUB_NIB2_END);
		end else begin
			// high nibble pulse, low nibble pulse, then settle
			phase.reg_select = reg_select;
			phase.enable = (sub == 3'd0) || (sub == 3'd2);
			phase.nibble = (sub < 3'd2) ? byte_value[7:4] : byte_value[3:0];
			phase.hold_ms = (sub == lcdn_pkg::SUB_BYTE_END) ? cfg.settle_ms : cfg.pulse_ms;
			seg_done = (sub == lcdn_pkg::SUB_BYTE_END);
		end
		phase.last = seg_done && (seg == lcdn_pkg::SEG_BYTE_LAST);
	end

endmodule

/* rtl/core/lcdn_seq.sv */
// sequencer: steps phases into the output register, one per cycle unless stalled
module lcdn_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  lcdn_pkg::cfg_t cfg,
	lcdn_req_if.sink       req,
	lcdn_rsp_if.source     rsp,
	output logic           busy
);

	logic             busy_q;
	logic [3:0]       seg_q;
	logic [2:0]       sub_q;
	logic [7:0]       byte_q;
	logic             rs_q;
	logic             out_valid_q;
	lcdn_pkg::phase_t out_q;

	lcdn_pkg::phase_t phase;
	logic             seg_done;
	logic             advance;
	logic [3:0]       next_seg;
	logic [5:0]       col_m1;
	logic [7:0]       req_byte;

	lcdn_phase u_phase (
		.seg        (seg_q),
		.sub        (sub_q),
		.byte_value (byte_q),
		.reg_select (rs_q),
		.cfg        (cfg),
		.phase      (phase),
		.seg_done   (seg_done)
	);

	assign advance = busy_q && (!out_valid_q || rsp.ready);
	assign next_seg = seg_q + 4'd1;
	assign req.ready = !busy_q;
	assign busy = busy_q;

	// cursor address, column clamped to 1..40
	always_comb begin
		priority if (req.column == 6'd0) begin
			col_m1 = 6'd0;
		end else if (req.column > lcdn_pkg::COL_MAX) begin
			col_m1 = lcdn_pkg::COL_MAX - 6'd1;
		end else begin
			col_m1 = req.column - 6'd1;
		end
		req_byte = (req.opcode == lcdn_pkg::OP_CURSOR) ? {1'b1, req.row[1], col_m1} :
		                                                 req.byte_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				busy_q <= 1'b1;
			end else if (advance && phase.last) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			sub_q <= 3'd0;
			byte_q <= req_byte;
			rs_q <= (req.opcode == lcdn_pkg::OP_DATA);
			seg_q <= (req.opcode == lcdn_pkg::OP_INIT) ? lcdn_pkg::SEG_ZERO :
			                                             lcdn_pkg::SEG_BYTE_LAST;
		end else if (advance) begin
			if (seg_done) begin
				seg_q <= next_seg;
				sub_q <= 3'd0;
				if (next_seg >= lcdn_pkg::SEG_BYTE_1) begin
					byte_q <= lcdn_pkg::init_cmd(next_seg);
				end
			end else begin
				sub_q <= sub_q + 3'd1;
			end
		end
		if (advance) begin
			out_q <= phase;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.reg_select = out_q.reg_select;
	assign rsp.enable = out_q.enable;
	assign rsp.nibble = out_q.nibble;
	assign rsp.hold_ms = out_q.hold_ms;
	assign rsp.last = out_q.last;

endmodule

/* rtl/core/char_lcd_nibble_interface_core.sv */
// top level of the 4-bit character display controller: timing registers and sequencer
// accept registers the request in the sequencer; its first phase enters the output register on the next advance
// throughput: one phase per cycle when the sink is ready; the sequencer steps the phases of
// a request in order and accepts the next request only after generating the last phase of
// the current one; output stalls hold the sequencer until the pending word is taken
// reset: timing registers return to 1, 2 and 5 ms, the block is idle with no word pending
module char_lcd_nibble_interface_core (
	input  logic       clk,
	input  logic       arst_n,
	lcdn_req_if.sink   req,
	lcdn_rsp_if.source rsp,
	lcdn_cfg_if.sink   cfg
);

	lcdn_pkg::cfg_t cfg_q;
	logic           busy;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_ms <= lcdn_pkg::PULSE_RST;
			cfg_q.settle_ms <= lcdn_pkg::SETTLE_RST;
			cfg_q.init_wait_ms <= lcdn_pkg::INIT_WAIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				lcdn_pkg::CFG_PULSE:     cfg_q.pulse_ms <= cfg.data;
				lcdn_pkg::CFG_SETTLE:    cfg_q.settle_ms <= cfg.data;
				lcdn_pkg::CFG_INIT_WAIT: cfg_q.init_wait_ms <= cfg.data;
				default:                 ;
			endcase
		end
	end

	lcdn_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.rsp    (rsp),
		.busy   (busy)
	);

`ifndef SYNTHESIS
	// a pending word that does not end its request means the sequencer is still busy
	a_mid_request_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last |-> busy && !req.ready)
		else $error("request accepted while phases still pending");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> busy)
		else $error("sequencer not busy after accept");

	// an enable-high phase is never last, so the next phase follows at once
	a_pulse_followed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && rsp.enable |=> rsp.valid && !rsp.enable)
		else $error("enable pulse not followed by enable-low phase");

	a_cfg_pulse_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready && cfg.index == lcdn_pkg::CFG_PULSE
		|=> cfg_q.pulse_ms == $past(cfg.data))
		else $error("pulse register not written");
`endif

endmodule
